/* rtl/core/fdm_pkg.sv */
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared types and constants for the floored divide and modulo unit.
// ----------------------------------------------------------------------------
package fdm_pkg;

  localparam int unsigned FieldWidth = 64;
  localparam int unsigned DataWidthDefault = 64;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusDivZero  = 2'd1,
    StatusOverflow = 2'd2
  } fdm_status_e;

  typedef struct packed {
    logic signed [FieldWidth-1:0] dividend;
    logic signed [FieldWidth-1:0] divisor;
  } fdm_req_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] quotient;
    logic signed [FieldWidth-1:0] remainder;
    fdm_status_e                  status;
  } fdm_rsp_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic yzero;
  } fdm_ctrl_t;

endpackage

/* rtl/core/fdm_div_stage.sv */
// ----------------------------------------------------------------------------
// fdm_div_stage
// One registered step of an unsigned restoring divider: retires one quotient
// bit per stage and carries the sign controls alongside.
// ----------------------------------------------------------------------------
module fdm_div_stage #(
  parameter int unsigned DATA_WIDTH = fdm_pkg::DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  fdm_pkg::fdm_ctrl_t    ctrl_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] quo_i,
  input  logic [DATA_WIDTH-1:0] dsr_i,
  output logic                  valid_o,
  output fdm_pkg::fdm_ctrl_t    ctrl_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output logic [DATA_WIDTH-1:0] dsr_o
);
  import fdm_pkg::*;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_d, rem_q;
  logic [DATA_WIDTH-1:0] quo_d, quo_q;
  logic [DATA_WIDTH-1:0] dsr_q;
  fdm_ctrl_t             ctrl_q;
  logic                  valid_q;

  always_comb begin
    trial = {rem_i, quo_i[DATA_WIDTH-1]};
    diff  = trial - {1'b0, dsr_i};
    fits  = ~diff[DATA_WIDTH];
    rem_d = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    quo_d = {quo_i[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dsr_q  <= dsr_i;
    ctrl_q <= ctrl_i;
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign dsr_o   = dsr_q;

endmodule

/* rtl/core/floored_divide_modulo_unit.sv */
// ----------------------------------------------------------------------------
// floored_divide_modulo_unit
// Pipelined signed division returning floored quotient and remainder.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy stays low: the pipeline takes one request every cycle.
//   Each request yields one response on rsp_o, marked by rsp_valid_o for
//   exactly one cycle. The pipeline follows the restoring divider: one
//   register stage per quotient bit, plus an operand stage (absolute values)
//   and a result stage (floored sign fix-up and status).
//   Operands use the low DATA_WIDTH bits of each field; results are
//   sign-extended to the full field width.
//   A zero divisor gives zero results with a divide-by-zero status; the most
//   negative dividend over minus one gives a wrapped quotient, zero remainder
//   and an overflow status.
//   Reset clears all valid bits, so no response follows reset until a new
//   request has gone through. The receiver cannot stall: a response is
//   present for one cycle only and must be taken then.
// ----------------------------------------------------------------------------
module floored_divide_modulo_unit #(
  parameter int unsigned DATA_WIDTH = fdm_pkg::DataWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fdm_pkg::fdm_req_t req_i,
  output logic              rsp_valid_o,
  output fdm_pkg::fdm_rsp_t rsp_o
);
  import fdm_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0] x, y;
  logic         accept;
  logic         valid_s [W+1];
  fdm_ctrl_t    ctrl_s  [W+1];
  logic [W-1:0] rem_s   [W+1];
  logic [W-1:0] quo_s   [W+1];
  logic [W-1:0] dsr_s   [W+1];

  logic         in_valid_q;
  fdm_ctrl_t    in_ctrl_q;
  logic [W-1:0] in_ax_q, in_ay_q;

  logic [W-1:0] tq, tr;
  logic [W-1:0] q_d, r_d;
  fdm_status_e  st_d;
  logic         out_valid_q;
  fdm_rsp_t     rsp_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign x      = req_i.dividend[W-1:0];
  assign y      = req_i.divisor[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_ctrl_q.xneg  <= x[W-1];
    in_ctrl_q.yneg  <= y[W-1];
    in_ctrl_q.yzero <= (y == '0);
    in_ax_q         <= x[W-1] ? (~x + 1'b1) : x;
    in_ay_q         <= y[W-1] ? (~y + 1'b1) : y;
  end

  assign valid_s[0] = in_valid_q;
  assign ctrl_s[0]  = in_ctrl_q;
  assign rem_s[0]   = '0;
  assign quo_s[0]   = in_ax_q;
  assign dsr_s[0]   = in_ay_q;

  for (genvar i = 0; i < W; i++) begin : g_stage
    fdm_div_stage #(
      .DATA_WIDTH(W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[i]),
      .ctrl_i (ctrl_s[i]),
      .rem_i  (rem_s[i]),
      .quo_i  (quo_s[i]),
      .dsr_i  (dsr_s[i]),
      .valid_o(valid_s[i+1]),
      .ctrl_o (ctrl_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .quo_o  (quo_s[i+1]),
      .dsr_o  (dsr_s[i+1])
    );
  end

  assign tq = quo_s[W];
  assign tr = rem_s[W];

  always_comb begin
    q_d  = '0;
    r_d  = '0;
    st_d = StatusOk;
    if (ctrl_s[W].yzero) begin
      st_d = StatusDivZero;
    end else if (ctrl_s[W].xneg == ctrl_s[W].yneg) begin
      q_d = tq;
      r_d = ctrl_s[W].yneg ? (~tr + 1'b1) : tr;
      if (ctrl_s[W].xneg && (tq == {1'b1, {(W-1){1'b0}}})) begin
        st_d = StatusOverflow;
      end
    end else if (tr == '0) begin
      q_d = ~tq + 1'b1;
    end else begin
      q_d = ~tq;
      r_d = ctrl_s[W].yneg ? (tr - dsr_s[W]) : (dsr_s[W] - tr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_s[W];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.quotient  <= FieldWidth'(signed'(q_d));
    rsp_q.remainder <= FieldWidth'(signed'(r_d));
    rsp_q.status    <= st_d;
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* rtl/core/fdm_checker.sv */
// ----------------------------------------------------------------------------
// fdm_checker
// Port-level checks on request to response timing, zero-divisor results and result signs.
// ----------------------------------------------------------------------------
module fdm_checker #(
  parameter int unsigned DATA_WIDTH = fdm_pkg::DataWidthDefault
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input fdm_pkg::fdm_req_t req_i,
  input logic              rsp_valid_o,
  input fdm_pkg::fdm_rsp_t rsp_o
);
  import fdm_pkg::*;

  localparam int unsigned Latency = DATA_WIDTH + 2;
  localparam int unsigned CntWidth = $clog2(Latency + 1);

  logic [CntWidth-1:0] cnt_q;
  logic                warm;
  logic                accept;

  assign accept = start && !busy;
  assign warm   = (cnt_q == CntWidth'(Latency));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (!warm) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && rsp_valid_o) |-> $past(accept, Latency))
    else $error("response without matching request");

  a_req_has_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && $past(accept, Latency)) |-> rsp_valid_o)
    else $error("request lost");

  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && rsp_valid_o && $past(req_i.divisor[DATA_WIDTH-1:0] == '0, Latency))
      |-> (rsp_o.quotient == '0 && rsp_o.remainder == '0 &&
           rsp_o.status == StatusDivZero))
    else $error("zero divisor result wrong");

  a_rem_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && rsp_valid_o && rsp_o.remainder != '0)
      |-> (rsp_o.remainder[FieldWidth-1] == $past(req_i.divisor[DATA_WIDTH-1], Latency)))
    else $error("remainder sign differs from divisor");

endmodule

bind floored_divide_modulo_unit fdm_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_fdm_checker (.*);

/* tb/fdm_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdm_result_checker
// Watches the request and response channels of the floored divide and modulo
// unit. It predicts each floored quotient, remainder and status, queues them
// in request order and compares every response field by field.
// ----------------------------------------------------------------------------
module fdm_result_checker #(
  parameter int unsigned DATA_WIDTH = fdm_pkg::DataWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  fdm_pkg::fdm_req_t req_i,
  input  logic              rsp_valid_i,
  input  fdm_pkg::fdm_rsp_t rsp_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  import fdm_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    fdm_req_t req;
    fdm_rsp_t rsp;
  } divmod_entry_t;

  divmod_entry_t divmod_results_q[$];
  divmod_entry_t oldest;
  int unsigned   fail_count;

  function automatic logic [63:0] wrap_to_width(logic [63:0] v);
    logic [63:0] mask;
    mask = (DATA_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << DATA_WIDTH) - 64'd1);
    v = v & mask;
    if (v[DATA_WIDTH-1]) begin
      v = v | ~mask;
    end
    return v;
  endfunction

  function automatic fdm_rsp_t floored_divmod(fdm_req_t r);
    logic [63:0] x, y, ax, ay, tq, tr, q, rm, sign_bit;
    logic        xneg, yneg;
    fdm_rsp_t    res;
    x        = wrap_to_width(r.dividend);
    y        = wrap_to_width(r.divisor);
    xneg     = x[63];
    yneg     = y[63];
    sign_bit = 64'd1 << (DATA_WIDTH - 1);
    if (y == 64'd0) begin
      res.quotient  = '0;
      res.remainder = '0;
      res.status    = StatusDivZero;
      return res;
    end
    ax = xneg ? 64'd0 - x : x;
    ay = yneg ? 64'd0 - y : y;
    tq = ax / ay;
    tr = ax % ay;
    if (xneg == yneg) begin
      q  = tq;
      rm = yneg ? 64'd0 - tr : tr;
    end else if (tr == 64'd0) begin
      q  = 64'd0 - tq;
      rm = 64'd0;
    end else begin
      q  = 64'd0 - (tq + 64'd1);
      rm = ay - tr;
      if (yneg) begin
        rm = 64'd0 - rm;
      end
    end
    res.quotient  = wrap_to_width(q);
    res.remainder = wrap_to_width(rm);
    res.status    = (xneg && yneg && tq == sign_bit) ? StatusOverflow : StatusOk;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divmod_results_q.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid_i) begin
        if (divmod_results_q.size() == 0) begin
          if (fail_count < ReportLimit) begin
            $display("%0t: unexpected response q=%0d r=%0d s=%0d", $time,
                     rsp_i.quotient, rsp_i.remainder, rsp_i.status);
          end
          fail_count++;
        end else begin
          oldest = divmod_results_q.pop_front();
          if (rsp_i.quotient !== oldest.rsp.quotient ||
              rsp_i.remainder !== oldest.rsp.remainder ||
              rsp_i.status !== oldest.rsp.status) begin
            if (fail_count < ReportLimit) begin
              $display("%0t: mismatch for %0d / %0d", $time,
                       oldest.req.dividend, oldest.req.divisor);
              $display("  expected q=%0d r=%0d s=%0d", oldest.rsp.quotient,
                       oldest.rsp.remainder, oldest.rsp.status);
              $display("  actual   q=%0d r=%0d s=%0d", rsp_i.quotient,
                       rsp_i.remainder, rsp_i.status);
            end
            fail_count++;
          end
        end
      end
      if (start_i && !busy_i) begin
        divmod_results_q.push_back('{req: req_i, rsp: floored_divmod(req_i)});
      end
    end
  end

  assign fail_count_o = fail_count;
  assign pending_o    = divmod_results_q.size();

endmodule

/* tb/floored_divide_modulo_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floored_divide_modulo_unit_tb
// Drives directed corner operands and then random operand pairs with random
// idle gaps into the floored divide and modulo unit; a checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
module floored_divide_modulo_unit_tb;
  import fdm_pkg::*;

  localparam int unsigned DataWidth     = DataWidthDefault;
  localparam int unsigned Latency       = DataWidth + 2;
  localparam int unsigned RandomItems   = 1730;
  localparam int unsigned WatchdogLimit = 2000;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MinusOne = 64'hffff_ffff_ffff_ffff;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  fdm_req_t    req;
  logic        rsp_valid;
  fdm_rsp_t    rsp;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  logic        no_idle;

  floored_divide_modulo_unit #(
    .DATA_WIDTH(DataWidth)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp)
  );

  fdm_result_checker #(
    .DATA_WIDTH(DataWidth)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .rsp_valid_i (rsp_valid),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic fdm_req_t operands(logic [63:0] a, logic [63:0] b);
    fdm_req_t r;
    r.dividend = a;
    r.divisor  = b;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] small_signed(int unsigned limit);
    logic [63:0] v;
    v = 64'($urandom_range(0, limit));
    return $urandom_range(0, 1) ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] edge_value();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'd1;
      2: return MinusOne;
      3: return MinVal;
      4: return MaxVal;
      5: return MinVal + 64'd1;
      6: return MaxVal - 64'd1;
      default: return small_signed(3);
    endcase
  endfunction

  function automatic fdm_req_t random_operands();
    logic [63:0] a, b;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      a = rand64();
      b = rand64();
    end else if (kind < 50) begin
      a = rand64();
      b = small_signed(16);
    end else if (kind < 65) begin
      a = small_signed(200);
      b = small_signed(20);
    end else if (kind < 75) begin
      b = small_signed(1000);
      if (b == 64'd0) begin
        b = 64'd7;
      end
      a = b * {{32{1'b0}}, $urandom} - (b << 31);
    end else if (kind < 85) begin
      a = edge_value();
      b = edge_value();
    end else if (kind < 92) begin
      a = rand64();
      b = 64'd0;
    end else begin
      a = $signed(rand64()) >>> $urandom_range(0, 63);
      b = $signed(rand64()) >>> $urandom_range(0, 63);
    end
    return operands(a, b);
  endfunction

  task automatic send_request(input fdm_req_t r);
    int unsigned pick, gap;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) begin
      gap = 0;
    end else if (pick < 88) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 97) begin
      gap = $urandom_range(4, 20);
    end else begin
      gap = $urandom_range(30, 150);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || rsp_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    req         = '0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(operands(64'd0, 64'd0));
    send_request(operands(64'd0, 64'd5));
    send_request(operands(64'd5, 64'd0));
    send_request(operands(MinVal, MinusOne));
    send_request(operands(MinVal, 64'd1));
    send_request(operands(MinVal, MinVal));
    send_request(operands(MaxVal, MaxVal));
    send_request(operands(MaxVal, MinusOne));
    send_request(operands(MaxVal, MinVal));
    send_request(operands(MinVal, MaxVal));
    send_request(operands(64'd0 - 64'd7, 64'd2));
    send_request(operands(64'd7, 64'd0 - 64'd2));
    send_request(operands(64'd0 - 64'd7, 64'd0 - 64'd2));
    send_request(operands(64'd7, 64'd2));
    send_request(operands(64'd0 - 64'd6, 64'd3));
    send_request(operands(64'd6, 64'd0 - 64'd3));
    send_request(operands(64'd1, MaxVal));
    send_request(operands(MinusOne, MaxVal));
    send_request(operands(MinusOne, MinVal));
    send_request(operands(MinusOne, MinusOne));
    send_request(operands(64'd1, MinusOne));
    send_request(operands(MaxVal, 64'd0));
    send_request(operands(MinVal, 64'd0));
    send_request(operands(64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555));
    send_request(operands(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa));

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 64 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (i == RandomItems / 2) begin
        drain_results();
      end
      send_request(random_operands());
    end

    drain_results();
    repeat (2 * Latency + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
